// ===== hw/rtl/rgbe_shared_exponent_codec_top_defines.svh =====
// Assertion macros for the RGBE codec top level.
`ifndef RGBE_SHARED_EXPONENT_CODEC_TOP_DEFINES_SVH
`define RGBE_SHARED_EXPONENT_CODEC_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define RGBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbe codec check failed");

// Check a consequence in the cycle after its condition.
`define RGBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbe codec check failed");

`endif

// ===== hw/rtl/rgbe_pkg.sv =====
package rgbe_pkg;

    // Default exponent range
    localparam int EXPONENT_LEVELS_DEF = 255;
    localparam int EXPONENT_BIAS_DEF   = 128;

    // Mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // binary32 and Q0.16 constants
    localparam logic [31:0] FP_POS_INF   = 32'h7F80_0000;
    localparam logic [31:0] FP_POS_ZERO  = 32'h0000_0000;
    localparam logic [7:0]  FP_EXP_SPEC  = 8'hFF;
    localparam logic [15:0] FRAC_MAX     = 16'hFFFF;

    typedef struct packed {
        logic        mode;
        logic [31:0] red_in;
        logic [31:0] green_in;
        logic [31:0] blue_in;
        logic [7:0]  exponent_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic [7:0]  exponent_out;
    } t_out_item;

endpackage

// ===== hw/rtl/rgbe_shared_exponent_codec_top.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------
// request  | in        | i_in_valid / o_in_stall  | i_in_data  (mode, RGB, exp)
// result   | out       | o_out_valid / i_out_stall| o_out_data (RGB, exp)
//
// One request per clock while o_in_stall is low; a taken request waits in the input
// register until the one compute pass fills the result register from it.
// Reset (i_rst_n low, synchronous) empties both registers; no clearing pass.
// A downstream stall holds the result; the input register keeps taking requests
// until it too is full, then o_in_stall rises.
`include "rgbe_shared_exponent_codec_top_defines.svh"

module rgbe_shared_exponent_codec_top #(
    parameter int EXPONENT_LEVELS = rgbe_pkg::EXPONENT_LEVELS_DEF,
    parameter int EXPONENT_BIAS   = rgbe_pkg::EXPONENT_BIAS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rgbe_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rgbe_pkg::t_out_item o_out_data
);

    localparam logic signed [10:0] LEVELS_S = 11'(EXPONENT_LEVELS);
    localparam logic signed [10:0] BIAS_S   = 11'(EXPONENT_BIAS);
    localparam logic [7:0]         LEVELS_U = 8'(EXPONENT_LEVELS);
    localparam logic signed [10:0] DEC_OFS  = 11'(111 - EXPONENT_BIAS);

    // Position of the highest set bit (0 when none)
    function automatic logic [4:0] f_top_bit(input logic [22:0] v);
        logic [4:0] p;
        begin
            p = 5'd0;
            for (int i = 0; i < 23; i++) begin
                if (v[i]) begin
                    p = 5'(i);
                end
            end
            return p;
        end
    endfunction

    // Drop sign-negative and NaN components to zero
    function automatic logic [31:0] f_clean(input logic [31:0] b);
        logic [31:0] res;
        begin
            res = b;
            if (b[31]) begin
                res = rgbe_pkg::FP_POS_ZERO;
            end else if (b[30:23] == rgbe_pkg::FP_EXP_SPEC && b[22:0] != 23'd0) begin
                res = rgbe_pkg::FP_POS_ZERO;
            end
            return res;
        end
    endfunction

    // Smallest index whose power of two covers the maximum
    function automatic logic [7:0] f_pick_index(input logic [31:0] mx);
        logic [7:0]         ef;
        logic [22:0]        fr;
        logic [4:0]         p;
        logic signed [10:0] c;
        logic signed [10:0] i;
        logic [7:0]         res;
        begin
            ef = mx[30:23];
            fr = mx[22:0];
            p  = f_top_bit(fr);
            if (ef != 8'd0) begin
                c = $signed({3'b000, ef}) - 11'sd127 + ((fr != 23'd0) ? 11'sd1 : 11'sd0);
            end else begin
                c = $signed({6'b000000, p}) - 11'sd149
                    + (((fr & (fr - 23'd1)) != 23'd0) ? 11'sd1 : 11'sd0);
            end
            i = c + BIAS_S;
            priority if (mx == 32'd0) begin
                res = 8'd1;
            end else if (ef == rgbe_pkg::FP_EXP_SPEC) begin
                res = LEVELS_U;
            end else if (i < 11'sd1) begin
                res = 8'd1;
            end else if (i > LEVELS_S) begin
                res = LEVELS_U;
            end else begin
                res = i[7:0];
            end
            return res;
        end
    endfunction

    // Scale one component by 2^-k into a saturated Q0.16 fraction
    function automatic logic [15:0] f_to_fraction(input logic [31:0] b,
                                                  input logic signed [10:0] k);
        logic [23:0]        m;
        logic signed [10:0] e2;
        logic signed [10:0] s;
        logic signed [10:0] ns;
        logic [38:0]        q_l;
        logic [23:0]        q_r;
        logic [15:0]        res;
        begin
            m   = {(b[30:23] != 8'd0), b[22:0]};
            e2  = (b[30:23] != 8'd0) ? ($signed({3'b000, b[30:23]}) - 11'sd150) : -11'sd149;
            s   = e2 - k + 11'sd16;
            ns  = -s;
            q_l = {15'd0, m} << s[3:0];
            q_r = m >> ns[4:0];
            priority if (b == 32'd0) begin
                res = 16'd0;
            end else if (b[30:23] == rgbe_pkg::FP_EXP_SPEC) begin
                res = rgbe_pkg::FRAC_MAX;
            end else if (s >= 11'sd16) begin
                res = rgbe_pkg::FRAC_MAX;
            end else if (s >= 11'sd0) begin
                res = (q_l[38:16] != 23'd0) ? rgbe_pkg::FRAC_MAX : q_l[15:0];
            end else if (s <= -11'sd24) begin
                res = 16'd0;
            end else begin
                res = (q_r[23:16] != 8'd0) ? rgbe_pkg::FRAC_MAX : q_r[15:0];
            end
            return res;
        end
    endfunction

    // Expand a Q0.16 fraction times 2^(n - bias) into binary32
    function automatic logic [31:0] f_from_fraction(input logic [15:0] f,
                                                    input logic [7:0] n);
        logic [4:0]         p;
        logic signed [10:0] e;
        logic [23:0]        norm;
        logic [31:0]        res;
        begin
            p    = f_top_bit({7'd0, f});
            e    = $signed({6'b000000, p}) + $signed({3'b000, n}) + DEC_OFS;
            norm = {8'd0, f} << (5'd23 - p);
            priority if (f == 16'd0) begin
                res = rgbe_pkg::FP_POS_ZERO;
            end else if (e >= 11'sd255) begin
                res = rgbe_pkg::FP_POS_INF;
            end else if (e <= 11'sd0) begin
                res = rgbe_pkg::FP_POS_ZERO;
            end else begin
                res = {1'b0, e[7:0], norm[22:0]};
            end
            return res;
        end
    endfunction

    logic                r_in_valid;
    rgbe_pkg::t_in_item  r_in;
    logic                r_out_valid;
    rgbe_pkg::t_out_item r_out;
    rgbe_pkg::t_out_item n_out;
    logic                out_ready;
    logic                in_take;

    logic [31:0]         cr;
    logic [31:0]         cg;
    logic [31:0]         cb;
    logic [31:0]         mx;
    logic [7:0]          idx;
    logic signed [10:0]  k;
    logic [7:0]          n_sat;

    // Handshake: result register frees when empty or taken
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !out_ready;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Encode: clean components, find maximum and shared index; decode: saturate the exponent
    always_comb begin
        cr    = f_clean(r_in.red_in);
        cg    = f_clean(r_in.green_in);
        cb    = f_clean(r_in.blue_in);
        mx    = (cg > cr) ? cg : cr;
        mx    = (cb > mx) ? cb : mx;
        idx   = f_pick_index(mx);
        k     = $signed({3'b000, idx}) - BIAS_S;
        n_sat = (r_in.exponent_in > LEVELS_U) ? LEVELS_U : r_in.exponent_in;
    end

    // Select the result for the current mode
    always_comb begin
        unique case (r_in.mode)
            rgbe_pkg::MODE_ENCODE: begin
                n_out.red_out      = {16'd0, f_to_fraction(cr, k)};
                n_out.green_out    = {16'd0, f_to_fraction(cg, k)};
                n_out.blue_out     = {16'd0, f_to_fraction(cb, k)};
                n_out.exponent_out = idx;
            end
            rgbe_pkg::MODE_DECODE: begin
                n_out.red_out      = f_from_fraction(r_in.red_in[15:0], n_sat);
                n_out.green_out    = f_from_fraction(r_in.green_in[15:0], n_sat);
                n_out.blue_out     = f_from_fraction(r_in.blue_in[15:0], n_sat);
                n_out.exponent_out = 8'd0;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Capture requests; advance into the result register when it frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_ready) begin
                r_in_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // Assertions
    `RGBE_ASSERT_NOW(a_stall_only_when_full, o_in_stall, r_in_valid && r_out_valid)
    `RGBE_ASSERT_NEXT(a_advance_fills_out, r_in_valid && out_ready, o_out_valid)
    `RGBE_ASSERT_NEXT(a_encode_index_range,
        r_in_valid && out_ready && r_in.mode == rgbe_pkg::MODE_ENCODE,
        o_out_data.exponent_out >= 8'd1 && o_out_data.exponent_out <= LEVELS_U &&
        o_out_data.red_out[31:16] == 16'd0 && o_out_data.blue_out[31:16] == 16'd0)
    `RGBE_ASSERT_NEXT(a_decode_index_zero,
        r_in_valid && out_ready && r_in.mode == rgbe_pkg::MODE_DECODE,
        o_out_data.exponent_out == 8'd0 && o_out_data.red_out[31] == 1'b0)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rgbe_pkg::*;

    localparam int LEVELS         = EXPONENT_LEVELS_DEF;
    localparam int BIAS           = EXPONENT_BIAS_DEF;
    localparam int RANDOM_PIXELS  = 1330;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_START     = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_pixel_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_pixel_row pixel_plan[$];
    t_out_item  expected_pixels[$];
    int         fail_count = 0;
    bit         stim_done  = 1'b0;

    rgbe_shared_exponent_codec_top #(
        .EXPONENT_LEVELS(LEVELS),
        .EXPONENT_BIAS  (BIAS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Hold reset at the start, then release it
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Pixel conversion predictor
    // ---------------------------------------------------------------
    function automatic int msb_index(logic [31:0] v);
        int p;
        p = -1;
        for (int n = 0; n < 32; n++) if (v[n]) p = n;
        return p;
    endfunction

    // Drop negatives, minus zero and NaN to plain zero
    function automatic logic [31:0] sanitize(logic [31:0] bits);
        if (bits[31]) return FP_POS_ZERO;
        if (bits[30:23] == FP_EXP_SPEC && bits[22:0] != 23'd0) return FP_POS_ZERO;
        return bits;
    endfunction

    function automatic void unpack_float(input logic [31:0] bits, output logic [31:0] mant,
                                         output int pow2);
        int ef;
        ef = bits[30:23];
        if (ef != 0) begin
            mant = {9'h001, bits[22:0]};
            pow2 = ef - 150;
        end else begin
            mant = {9'h000, bits[22:0]};
            pow2 = -149;
        end
    endfunction

    // Smallest index whose power of two covers the peak component
    function automatic int shared_index(logic [31:0] peak);
        logic [31:0] mant;
        int          pow2;
        int          top;
        int          idx;
        if (peak == 32'd0) return 1;
        if (peak[30:23] == FP_EXP_SPEC) return LEVELS;
        unpack_float(peak, mant, pow2);
        top = msb_index(mant);
        idx = top + pow2 + BIAS + ((mant != (32'd1 << top)) ? 1 : 0);
        if (idx < 1) idx = 1;
        if (idx > LEVELS) idx = LEVELS;
        return idx;
    endfunction

    // Divide by 2^scale_pow, truncate to Q0.16, saturate at the top
    function automatic logic [15:0] fraction_q16(logic [31:0] bits, int scale_pow);
        logic [31:0] mant;
        int          pow2;
        int          sh;
        logic [63:0] q;
        if (bits == 32'd0) return 16'd0;
        if (bits[30:23] == FP_EXP_SPEC) return FRAC_MAX;
        unpack_float(bits, mant, pow2);
        sh = pow2 - scale_pow + 16;
        if (sh >= 0) begin
            if (sh >= 24) return FRAC_MAX;
            q = {32'h0, mant} << sh;
        end else begin
            if (-sh >= 32) return 16'd0;
            q = {32'h0, mant >> (-sh)};
        end
        return (q > 64'hFFFF) ? FRAC_MAX : q[15:0];
    endfunction

    // Scale a Q0.16 fraction by 2^(idx - bias) into binary32
    function automatic logic [31:0] float_from_q16(logic [15:0] frac, int idx);
        int          top;
        int          e;
        logic [31:0] wide;
        if (frac == 16'd0) return FP_POS_ZERO;
        top = msb_index({16'h0, frac});
        e = top + idx - BIAS - 16 + 127;
        if (e >= 255) return FP_POS_INF;
        if (e <= 0) return FP_POS_ZERO;
        wide = {16'h0, frac} << (23 - top);
        return {1'b0, e[7:0], wide[22:0]};
    endfunction

    function automatic t_out_item convert_pixel(t_in_item req);
        t_out_item   res;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        logic [31:0] peak;
        int          idx;
        int          k;
        res = '0;
        if (req.mode == MODE_ENCODE) begin
            r = sanitize(req.red_in);
            g = sanitize(req.green_in);
            b = sanitize(req.blue_in);
            peak = r;
            if (g > peak) peak = g;
            if (b > peak) peak = b;
            idx = shared_index(peak);
            k = idx - BIAS;
            res.red_out      = {16'h0, fraction_q16(r, k)};
            res.green_out    = {16'h0, fraction_q16(g, k)};
            res.blue_out     = {16'h0, fraction_q16(b, k)};
            res.exponent_out = idx[7:0];
        end else begin
            idx = req.exponent_in;
            if (idx > LEVELS) idx = LEVELS;
            res.red_out   = float_from_q16(req.red_in[15:0], idx);
            res.green_out = float_from_q16(req.green_in[15:0], idx);
            res.blue_out  = float_from_q16(req.blue_in[15:0], idx);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus plan
    // ---------------------------------------------------------------
    function automatic t_out_item pix_result(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                             logic [7:0] e);
        t_out_item res;
        res.red_out      = r;
        res.green_out    = g;
        res.blue_out     = b;
        res.exponent_out = e;
        return res;
    endfunction

    function automatic void add_pixel(logic mode, logic [31:0] r, logic [31:0] g,
                                      logic [31:0] b, logic [7:0] e, bit typed,
                                      t_out_item want);
        t_pixel_row row;
        row.req.mode        = mode;
        row.req.red_in      = r;
        row.req.green_in    = g;
        row.req.blue_in     = b;
        row.req.exponent_in = e;
        row.typed           = typed;
        row.want            = want;
        pixel_plan.push_back(row);
    endfunction

    // Non-negative finite float at or up to 20 below the given biased exponent
    function automatic logic [31:0] rand_float(int base);
        int          ex;
        logic [22:0] mant;
        ex = base - int'($urandom_range(0, 20));
        if (ex < 0) ex = 0;
        if (ex > 254) ex = 254;
        mant = 23'($urandom());
        if ($urandom_range(0, 5) == 0) mant = '0;
        return {1'b0, ex[7:0], mant};
    endfunction

    function automatic logic [31:0] special_float();
        case ($urandom_range(0, 8))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return FP_POS_INF;
            3: return 32'hFF80_0000;
            4: return {1'b0, FP_EXP_SPEC, 1'b1, 22'($urandom())};
            5: return {$urandom_range(0, 1) == 1, FP_EXP_SPEC, 22'h0, 1'b1};
            6: return {1'b1, 31'($urandom())};
            7: return {9'h000, 23'($urandom())};
            default: return 32'h7F7F_FFFF;
        endcase
    endfunction

    function automatic void build_plan();
        int          kind;
        int          base;
        logic [31:0] c[3];
        logic [7:0]  e;
        t_out_item   none;
        none = '0;
        // Directed rows: specials typed in, the rest left to the predictor
        add_pixel(MODE_ENCODE, 0, 0, 0, 8'hFF, 1, pix_result(0, 0, 0, 1));
        add_pixel(MODE_ENCODE, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 0, 1,
                  pix_result(32'(FRAC_MAX), 32'(FRAC_MAX), 32'(FRAC_MAX), 128));
        add_pixel(MODE_ENCODE, FP_POS_INF, 0, 0, 0, 1,
                  pix_result(32'(FRAC_MAX), 0, 0, 8'(LEVELS)));
        add_pixel(MODE_ENCODE, 32'h7FC0_0000, 32'hBF80_0000, 32'h8000_0000, 8'h55, 1,
                  pix_result(0, 0, 0, 1));
        add_pixel(MODE_ENCODE, 32'hFFFF_FFFF, 32'h7F80_0001, 32'hFF80_0000, 8'hAA, 1,
                  pix_result(0, 0, 0, 1));
        add_pixel(MODE_ENCODE, FP_POS_INF, FP_POS_INF, FP_POS_INF, 0, 1,
                  pix_result(32'(FRAC_MAX), 32'(FRAC_MAX), 32'(FRAC_MAX), 8'(LEVELS)));
        add_pixel(MODE_ENCODE, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h0000_0001, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h007F_FFFF, 32'h0080_0000, 32'h0000_0000, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h3F00_0000, 32'h3E80_0000, 32'h3F40_0000, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h7F00_0000, 32'h3F80_0000, 32'h0000_0000, 0, 0, none);
        add_pixel(MODE_ENCODE, 32'h3FC0_0000, 32'h4000_0000, 32'h3F80_0001, 0, 0, none);
        add_pixel(MODE_DECODE, 0, 0, 0, 8'hC8, 1, pix_result(0, 0, 0, 0));
        add_pixel(MODE_DECODE, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 8'h80, 1,
                  pix_result(0, 0, 0, 0));
        add_pixel(MODE_DECODE, 1, 1, 1, 8'h00, 1, pix_result(0, 0, 0, 0));
        add_pixel(MODE_DECODE, 32'hFFFF, 32'hFFFF, 32'hFFFF, 8'hFF, 0, none);
        add_pixel(MODE_DECODE, 32'h8000, 32'h4000, 32'h0001, 8'h80, 0, none);
        add_pixel(MODE_DECODE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_ABCD, 8'hFF, 0, none);
        add_pixel(MODE_DECODE, 32'h0001, 32'h8000, 32'hFFFF, 8'h11, 0, none);
        add_pixel(MODE_DECODE, 32'h0001, 32'h0002, 32'h0003, 8'h12, 0, none);

        // Random rows: encode pixels (well-formed, with specials, or raw noise) and decode rows
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            kind = $urandom_range(0, 9);
            e = 8'($urandom());
            if (kind <= 4) begin
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(0, 12);
                    1: base = $urandom_range(240, 254);
                    default: base = $urandom_range(0, 254);
                endcase
                for (int j = 0; j < 3; j++) c[j] = rand_float(base);
                if (kind == 4) begin
                    c[$urandom_range(0, 2)] = special_float();
                    if ($urandom_range(0, 1) == 1) c[$urandom_range(0, 2)] = special_float();
                end
                add_pixel(MODE_ENCODE, c[0], c[1], c[2], e, 0, none);
            end else if (kind == 5) begin
                add_pixel(MODE_ENCODE, $urandom(), $urandom(), $urandom(), e, 0, none);
            end else begin
                for (int j = 0; j < 3; j++) begin
                    c[j] = $urandom();
                    if ($urandom_range(0, 1) == 1) c[j] = c[j] >> $urandom_range(0, 31);
                end
                if ($urandom_range(0, 4) == 0)
                    e = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(0, 20));
                add_pixel(MODE_DECODE, c[0], c[1], c[2], e, 0, none);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Request sender: bursts of random length with random gaps
    // ---------------------------------------------------------------
    initial begin : request_sender
        int next_idx;
        int taken;
        int burst_left;
        int gap_left;
        build_plan();
        next_idx   = 0;
        taken      = 0;
        burst_left = 0;
        gap_left   = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (taken < pixel_plan.size()) begin
            // Record the request taken at this edge
            if (i_in_valid && !o_in_stall) begin
                if (pixel_plan[taken].typed)
                    expected_pixels.push_back(pixel_plan[taken].want);
                else
                    expected_pixels.push_back(convert_pixel(pixel_plan[taken].req));
                taken++;
            end
            // Hold a stalled request, else idle or offer the next one
            if (i_in_valid && o_in_stall) begin
            end else if (next_idx >= pixel_plan.size()) begin
                i_in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= pixel_plan[next_idx].req;
                next_idx++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            @(posedge i_clk);
        end
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Result receiver: stall pattern plus one long hold-off
    // ---------------------------------------------------------------
    initial begin : result_stall
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                i_out_stall <= 1'b1;
            end else begin
                case ((cyc / 97) % 4)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= cyc[0];
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Result check against the oldest expected pixel
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_out_data);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.red_out, o_out_data.red_out);
                check_field("green_out", want.green_out, o_out_data.green_out);
                check_field("blue_out", want.blue_out, o_out_data.blue_out);
                check_field("exponent_out", {24'h0, want.exponent_out},
                            {24'h0, o_out_data.exponent_out});
            end
        end
    end

    // Abort when no handshake completes for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Drain outstanding results, then report
    initial begin : run_end
        wait (stim_done);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
